>>> rtl/spor_pkg.sv
// Shared types and widths for the sphere pair overlap resolver.
package spor_pkg;

  // Axis components are exact 33 bit differences of Q16.16 coordinates
  localparam int unsigned AxW   = 33;
  localparam int unsigned SqW   = 2 * AxW;       // one squared component
  localparam int unsigned SsW   = SqW + 2;       // sum of three squares
  localparam int unsigned RootW = 37;            // floor root of the sum
  localparam int unsigned RadW  = 2 * RootW;     // radicand, padded to root pairs
  localparam int unsigned SrW   = RootW + 3;     // root remainder
  localparam int unsigned RsW   = 32;            // sum of radii
  localparam int unsigned OvW   = 32;            // positive overlap
  localparam int unsigned DenW  = RootW + 1;     // twice the distance
  localparam int unsigned PrW   = AxW + OvW;     // |axis| * overlap
  localparam int unsigned QW    = 32;            // push magnitude
  localparam int unsigned DrW   = DenW + 1;      // divider remainder
  localparam int unsigned Lanes = 3;
  localparam int unsigned PushW = 32;

  // Geometry carried along the front pipeline
  typedef struct packed {
    logic [Lanes-1:0][AxW-1:0] axis;
    logic [RsW-1:0]            rsum;
  } geo_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [Lanes-1:0][AxW-1:0] axis;
    logic [OvW-1:0]            ov;
    logic [DenW-1:0]           den;
    logic                      hit;
    logic                      nz;
  } job_t;

  // Finished result
  typedef struct packed {
    logic [Lanes-1:0][PushW-1:0] push;
    logic                        hit;
  } res_t;

  // Magnitude of a 33 bit two's complement value (fits in 33 bits unsigned)
  function automatic logic [AxW-1:0] mag33(input logic [AxW-1:0] a);
    mag33 = a[AxW-1] ? (~a + AxW'(1)) : a;
  endfunction

endpackage

>>> rtl/spor_if.sv
// Channel interfaces: sphere pair in, push result out.
interface spor_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic        [30:0] first_radius;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic        [30:0] second_radius;

  modport source (output valid, first_x, first_y, first_z, first_radius,
                  second_x, second_y, second_z, second_radius, input ready);
  modport sink   (input valid, first_x, first_y, first_z, first_radius,
                  second_x, second_y, second_z, second_radius, output ready);
endinterface

interface spor_push_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;
  logic signed [31:0] push_z;
  logic               hit;

  modport source (output valid, push_x, push_y, push_z, hit, input ready);
  modport sink   (input valid, push_x, push_y, push_z, hit, output ready);
endinterface

>>> rtl/spor_front.sv
// Front pipeline: axis, sum of squares, bit-serial square root, overlap test.
module spor_front
  import spor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spor_pair_if.sink   pair_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic en;

  // stage 0: axis and radius sum
  logic s0_v_q;
  geo_t s0_q;
  // stage 1: squares
  logic s1_v_q;
  geo_t s1_q;
  logic [Lanes-1:0][SqW-1:0] s1_sq_q;
  // stage 2: sum of squares
  logic s2_v_q;
  geo_t s2_q;
  logic [SsW-1:0] s2_ss_q;
  // root stages
  logic             rt_v_q    [RootW];
  geo_t             rt_geo_q  [RootW];
  logic [RadW-1:0]  rt_s_q    [RootW];
  logic [SrW-1:0]   rt_rem_q  [RootW];
  logic [RootW-1:0] rt_root_q [RootW];
  // classified output
  logic out_v_q;
  job_t job_q;

  // whole pipeline moves unless the queue refuses the last item
  assign en           = !out_v_q || !full_i;
  assign pair_i.ready = en;
  assign push_o       = out_v_q && !full_i;
  assign job_o        = job_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q  <= pair_i.valid;
      s1_v_q  <= s0_v_q;
      s2_v_q  <= s1_v_q;
      out_v_q <= rt_v_q[RootW-1];
    end
  end

  // axis, squares and their sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q.axis[0] <= {pair_i.first_x[31], pair_i.first_x}
                      - {pair_i.second_x[31], pair_i.second_x};
      s0_q.axis[1] <= {pair_i.first_y[31], pair_i.first_y}
                      - {pair_i.second_y[31], pair_i.second_y};
      s0_q.axis[2] <= {pair_i.first_z[31], pair_i.first_z}
                      - {pair_i.second_z[31], pair_i.second_z};
      s0_q.rsum    <= {1'b0, pair_i.first_radius} + {1'b0, pair_i.second_radius};
      s1_q         <= s0_q;
      for (int l = 0; l < Lanes; l++) begin
        s1_sq_q[l] <= SqW'(mag33(s0_q.axis[l])) * SqW'(mag33(s0_q.axis[l]));
      end
      s2_q    <= s1_q;
      s2_ss_q <= SsW'(s1_sq_q[0]) + SsW'(s1_sq_q[1]) + SsW'(s1_sq_q[2]);
    end
  end

  // one root bit per stage, two radicand bits consumed each time
  for (genvar k = 0; k < RootW; k++) begin : g_root
    logic             v_in;
    geo_t             geo_in;
    logic [RadW-1:0]  s_in;
    logic [SrW-1:0]   rem_in;
    logic [RootW-1:0] root_in;
    logic [SrW-1:0]   rem_sh;
    logic [SrW-1:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = s2_v_q;
      assign geo_in  = s2_q;
      assign s_in    = RadW'(s2_ss_q);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = rt_v_q[k-1];
      assign geo_in  = rt_geo_q[k-1];
      assign s_in    = rt_s_q[k-1];
      assign rem_in  = rt_rem_q[k-1];
      assign root_in = rt_root_q[k-1];
    end

    assign rem_sh = {rem_in[SrW-3:0], s_in[RadW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v_q[k] <= 1'b0;
      end else if (en) begin
        rt_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_geo_q[k]  <= geo_in;
        rt_s_q[k]    <= {s_in[RadW-3:0], 2'b00};
        rt_rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        rt_root_q[k] <= {root_in[RootW-2:0], take};
      end
    end
  end

  // overlap and classification
  logic [RootW-1:0] root_dist;
  logic [RootW+1:0] ovs;
  assign root_dist = rt_root_q[RootW-1];
  assign ovs       = (RootW+2)'(rt_geo_q[RootW-1].rsum) - (RootW+2)'(root_dist);

  always_ff @(posedge clk_i) begin
    if (en) begin
      job_q.axis <= rt_geo_q[RootW-1].axis;
      job_q.ov   <= ovs[OvW-1:0];
      job_q.den  <= {root_dist, 1'b0};
      job_q.hit  <= !ovs[RootW+1] && (ovs != '0);
      job_q.nz   <= root_dist != '0;
    end
  end

endmodule

>>> rtl/spor_fifo.sv
// Short queue of classified items between front and back.
module spor_fifo
  import spor_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> rtl/spor_back.sv
// Back pipeline: scale axis by overlap, divide by twice the distance, saturate.
module spor_back
  import spor_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef struct packed {
    logic [DenW-1:0]  den;
    logic             hit;
    logic             nz;
    logic [Lanes-1:0] neg;
  } ctl_t;

  logic en;

  // product stage
  logic                      b0_v_q;
  ctl_t                      b0_ctl_q;
  logic [Lanes-1:0][PrW-1:0] b0_pr_q;
  // divider stages
  logic                      dv_v_q   [QW];
  ctl_t                      dv_ctl_q [QW];
  logic [Lanes-1:0][DrW-1:0] dv_rem_q [QW];
  logic [Lanes-1:0][QW-1:0]  dv_low_q [QW];
  logic [Lanes-1:0][QW-1:0]  dv_quo_q [QW];
  // output register
  logic out_v_q;
  res_t res_q;

  assign en          = !out_v_q || res_ready_i;
  assign pop_o       = en && !empty_i;
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b0_v_q  <= !empty_i;
      out_v_q <= dv_v_q[QW-1];
    end
  end

  // |axis| * overlap, one multiplier per lane
  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_ctl_q.den <= job_i.den;
      b0_ctl_q.hit <= job_i.hit;
      b0_ctl_q.nz  <= job_i.nz;
      for (int l = 0; l < Lanes; l++) begin
        b0_ctl_q.neg[l] <= job_i.axis[l][AxW-1];
        b0_pr_q[l]      <= PrW'(mag33(job_i.axis[l])) * PrW'(job_i.ov);
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic                      v_in;
    ctl_t                      ctl_in;
    logic [Lanes-1:0][DrW-1:0] rem_in;
    logic [Lanes-1:0][QW-1:0]  low_in;
    logic [Lanes-1:0][QW-1:0]  quo_in;

    if (j == 0) begin : g_first
      assign v_in   = b0_v_q;
      assign ctl_in = b0_ctl_q;
      for (genvar l = 0; l < Lanes; l++) begin : g_ln
        assign rem_in[l] = DrW'(b0_pr_q[l][PrW-1:QW]);
        assign low_in[l] = b0_pr_q[l][QW-1:0];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign ctl_in = dv_ctl_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign low_in = dv_low_q[j-1];
      assign quo_in = dv_quo_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (en) begin
        dv_v_q[j] <= v_in;
      end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [DrW-1:0] sh;
      logic           take;
      assign sh   = {rem_in[l][DrW-2:0], low_in[l][QW-1]};
      assign take = sh >= DrW'(ctl_in.den);

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[j][l] <= take ? (sh - DrW'(ctl_in.den)) : sh;
          dv_low_q[j][l] <= {low_in[l][QW-2:0], 1'b0};
          dv_quo_q[j][l] <= {quo_in[l][QW-2:0], take};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_ctl_q[j] <= ctl_in;
      end
    end
  end

  // sign, saturation and the no-move cases
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.hit <= dv_ctl_q[QW-1].hit;
      for (int l = 0; l < Lanes; l++) begin
        if (!dv_ctl_q[QW-1].hit || !dv_ctl_q[QW-1].nz) begin
          res_q.push[l] <= '0;
        end else if (dv_ctl_q[QW-1].neg[l]) begin
          res_q.push[l] <= dv_quo_q[QW-1][l][QW-1] ? {1'b1, {(PushW-1){1'b0}}}
                                                  : (~dv_quo_q[QW-1][l] + PushW'(1));
        end else begin
          res_q.push[l] <= dv_quo_q[QW-1][l][QW-1] ? {1'b0, {(PushW-1){1'b1}}}
                                                  : dv_quo_q[QW-1][l];
        end
      end
    end
  end

endmodule

>>> rtl/sphere_pair_overlap_resolve.sv
// Sphere pair overlap resolver: one pair in, one push displacement out.
// Throughput: one pair per cycle while neither the queue nor the result channel stalls.
// The front pipeline (37 stage square root) and back pipeline (32 stage divider per lane)
// are parted by a queue of QUEUE_DEPTH items, so each side stalls on its own.
// Reset clears all valid bits and queue pointers; no clearing pass is needed.
module sphere_pair_overlap_resolve
  import spor_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spor_pair_if.sink    pair_i,
  spor_push_if.source  push_o
);

  logic f_push, q_full, q_empty, b_pop;
  job_t f_job, q_job;
  res_t res;

  spor_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair_i),
    .full_i (q_full),
    .push_o (f_push),
    .job_o  (f_job)
  );

  spor_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .job_i   (f_job),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .empty_o (q_empty),
    .job_o   (q_job)
  );

  spor_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (q_job),
    .pop_o       (b_pop),
    .res_valid_o (push_o.valid),
    .res_ready_i (push_o.ready),
    .res_o       (res)
  );

  // result fields onto the channel
  assign push_o.push_x = res.push[0];
  assign push_o.push_y = res.push[1];
  assign push_o.push_z = res.push[2];
  assign push_o.hit    = res.hit;

endmodule

>>> tb/sv/tb_sphere_pair_overlap_resolve.sv
// Testbench for the sphere pair overlap resolver: random pairs, predicted pushes, stalls.
`timescale 1ns / 100ps

module tb_sphere_pair_overlap_resolve;
  import spor_pkg::*;

  // One pair of spheres as driven onto the input channel
  typedef struct packed {
    logic [2:0][31:0] first_c;
    logic [30:0]      first_r;
    logic [2:0][31:0] second_c;
    logic [30:0]      second_r;
  } sphere_pair_t;

  // Expected displacement of the first sphere
  typedef struct packed {
    logic [2:0][31:0] push;
    logic             hit;
  } displacement_t;

  localparam int unsigned NumRandom  = 1950;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 200;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spor_pair_if pair_if ();
  spor_push_if push_if ();

  sphere_pair_overlap_resolve dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair_if.sink),
    .push_o (push_if.source)
  );

  sphere_pair_t  pending_pairs[$];
  displacement_t expected_pushes[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_gap;
  int unsigned   stall_left;
  bit            send_burst;
  bit            recv_burst;

  always #5 clk_i = ~clk_i;

  // Exact fixed-point push: floor root for the distance, truncating divide, clamp
  function automatic displacement_t resolve_pair(sphere_pair_t p);
    logic signed [32:0] axis[3];
    logic [32:0]        mag[3];
    logic [127:0]       sumsq;
    logic [127:0]       cand;
    logic [127:0]       quo;
    logic [36:0]        dist_len;
    logic [31:0]        rsum;
    logic signed [39:0] ov;
    displacement_t      r;
    r        = '0;
    dist_len = '0;
    sumsq    = '0;
    for (int i = 0; i < 3; i++) begin
      axis[i] = $signed({p.first_c[i][31], p.first_c[i]})
              - $signed({p.second_c[i][31], p.second_c[i]});
      mag[i]  = axis[i][32] ? 33'(-axis[i]) : 33'(axis[i]);
      sumsq   = sumsq + {95'b0, mag[i]} * {95'b0, mag[i]};
    end
    for (int b = 36; b >= 0; b--) begin
      cand = {91'b0, dist_len} | (128'd1 << b);
      if (cand * cand <= sumsq) dist_len = cand[36:0];
    end
    rsum = {1'b0, p.first_r} + {1'b0, p.second_r};
    ov   = $signed({8'b0, rsum}) - $signed({3'b0, dist_len});
    if (ov <= 0) return r;
    r.hit = 1'b1;
    // coincident centres: no axis, so no move
    if (dist_len == '0) return r;
    for (int i = 0; i < 3; i++) begin
      quo = ({95'b0, mag[i]} * {88'b0, ov}) / ({91'b0, dist_len} << 1);
      if (axis[i][32])
        r.push[i] = (quo > 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo[31:0]);
      else
        r.push[i] = (quo > 128'h7fff_ffff) ? 32'h7fff_ffff : quo[31:0];
    end
    return r;
  endfunction

  function automatic sphere_pair_t make_pair(logic [2:0][31:0] a, logic [30:0] ra,
                                             logic [2:0][31:0] b, logic [30:0] rb);
    sphere_pair_t p;
    p.first_c  = a;
    p.first_r  = ra;
    p.second_c = b;
    p.second_r = rb;
    return p;
  endfunction

  // Mostly nearby pairs at varied scales so overlaps happen; the rest fully random
  function automatic sphere_pair_t random_pair();
    sphere_pair_t p;
    int unsigned  shift;
    p.first_c  = {$urandom, $urandom, $urandom};
    p.first_r  = 31'($urandom);
    p.second_r = 31'($urandom);
    p.second_c = {$urandom, $urandom, $urandom};
    if ($urandom_range(9) < 7) begin
      shift = $urandom_range(31, 4);
      for (int i = 0; i < 3; i++)
        p.second_c[i] = p.first_c[i] + 32'($signed($urandom) >>> shift);
      if ($urandom_range(3) == 0) p.second_c[$urandom_range(2)] = p.first_c[0];
      p.first_r  = 31'($urandom >> ($urandom_range(shift, shift > 1 ? shift - 2 : 0) + 1));
      p.second_r = 31'($urandom >> ($urandom_range(shift, shift > 1 ? shift - 2 : 0) + 1));
    end
    return p;
  endfunction

  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    roll = $urandom_range(99);
    if (burst || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: offers the next pending pair, records its prediction on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_if.valid         <= 1'b0;
      pair_if.first_x       <= '0;
      pair_if.first_y       <= '0;
      pair_if.first_z       <= '0;
      pair_if.first_radius  <= '0;
      pair_if.second_x      <= '0;
      pair_if.second_y      <= '0;
      pair_if.second_z      <= '0;
      pair_if.second_radius <= '0;
      send_gap              <= 0;
      send_burst            <= 1'b0;
    end else begin
      if (pair_if.valid && pair_if.ready)
        expected_pushes.push_back(resolve_pair(make_pair(
          {pair_if.first_z, pair_if.first_y, pair_if.first_x}, pair_if.first_radius,
          {pair_if.second_z, pair_if.second_y, pair_if.second_x},
          pair_if.second_radius)));
      if (!pair_if.valid || pair_if.ready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          pair_if.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          sphere_pair_t p;
          p = pending_pairs.pop_front();
          pair_if.first_x       <= p.first_c[0];
          pair_if.first_y       <= p.first_c[1];
          pair_if.first_z       <= p.first_c[2];
          pair_if.first_radius  <= p.first_r;
          pair_if.second_x      <= p.second_c[0];
          pair_if.second_y      <= p.second_c[1];
          pair_if.second_z      <= p.second_c[2];
          pair_if.second_radius <= p.second_r;
          pair_if.valid         <= 1'b1;
          if ($urandom_range(60) == 0) send_burst <= ~send_burst;
          send_gap <= pick_gap(send_burst);
        end else begin
          pair_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compares each accepted push with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_if.ready <= 1'b0;
      stall_left    <= 0;
      recv_burst    <= 1'b0;
    end else begin
      if (push_if.valid && push_if.ready) begin
        if (expected_pushes.size() == 0) begin
          report_mismatch("unexpected item", {31'b0, push_if.hit}, 32'b0);
        end else begin
          displacement_t w;
          w = expected_pushes.pop_front();
          if (push_if.push_x !== w.push[0]) report_mismatch("push_x", push_if.push_x, w.push[0]);
          if (push_if.push_y !== w.push[1]) report_mismatch("push_y", push_if.push_y, w.push[1]);
          if (push_if.push_z !== w.push[2]) report_mismatch("push_z", push_if.push_z, w.push[2]);
          if (push_if.hit !== w.hit) report_mismatch("hit", {31'b0, push_if.hit}, {31'b0, w.hit});
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        push_if.ready <= 1'b0;
      end else begin
        push_if.ready <= 1'b1;
        if ($urandom_range(80) == 0) recv_burst <= ~recv_burst;
        stall_left <= pick_gap(recv_burst);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[sphere_pair_overlap_resolve] ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0][31:0] zero3;
    logic [2:0][31:0] maxc;
    logic [2:0][31:0] minc;
    zero3 = '0;
    maxc  = {3{32'h7fff_ffff}};
    minc  = {3{32'h8000_0000}};

    // Directed: coincident, touching, extremes of every field
    pending_pairs.push_back(make_pair(zero3, '0, zero3, '0));
    pending_pairs.push_back(make_pair(zero3, 31'h0001_0000, zero3, '0));
    pending_pairs.push_back(make_pair(maxc, '1, maxc, '1));
    pending_pairs.push_back(make_pair(minc, '1, maxc, '1));
    pending_pairs.push_back(make_pair(maxc, '1, minc, '1));
    pending_pairs.push_back(make_pair({32'h0, 32'h0, 32'h0002_0000}, 31'h0001_0000,
                                      zero3, 31'h0001_0000));
    pending_pairs.push_back(make_pair({32'h0, 32'h0, 32'h0002_0000}, 31'h0001_0001,
                                      zero3, 31'h0001_0000));
    pending_pairs.push_back(make_pair({32'h0, 32'h0, 32'h1}, '1, zero3, '1));
    pending_pairs.push_back(make_pair(zero3, '1, {32'h0, 32'h0, 32'h1}, '1));
    pending_pairs.push_back(make_pair({32'h0, 32'h1, 32'h0}, '1, zero3, '1));
    pending_pairs.push_back(make_pair(zero3, '1, {32'h1, 32'h0, 32'h0}, '1));
    pending_pairs.push_back(make_pair({32'h1, 32'hffff_ffff, 32'h1}, '1, zero3, '1));
    pending_pairs.push_back(make_pair(maxc, '1, {3{32'h7fff_fffe}}, '0));
    pending_pairs.push_back(make_pair(minc, '0, {3{32'h8000_0001}}, '1));
    pending_pairs.push_back(make_pair({32'h0003_0000, 32'hfffc_0000, 32'h0001_8000},
                                      31'h0004_0000, zero3, 31'h0002_0000));
    pending_pairs.push_back(make_pair({32'h7fff_ffff, 32'h0, 32'h8000_0000}, '1,
                                      {32'h8000_0000, 32'h0, 32'h7fff_ffff}, '1));
    pending_pairs.push_back(make_pair(zero3, '1, maxc, '0));
    pending_pairs.push_back(make_pair({3{32'h5555_5555}}, 31'h2aaa_aaaa,
                                      {3{32'haaaa_aaaa}}, 31'h5555_5555));

    for (int i = 0; i < NumRandom; i++) pending_pairs.push_back(random_pair());

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_pairs.size() == 0 && !pair_if.valid);
    wait (expected_pushes.size() == 0);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0 && expected_pushes.size() == 0)
      $display("[sphere_pair_overlap_resolve] OK");
    else
      $display("[sphere_pair_overlap_resolve] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/spor_pkg.sv
rtl/spor_if.sv
rtl/spor_front.sv
rtl/spor_fifo.sv
rtl/spor_back.sv
rtl/sphere_pair_overlap_resolve.sv
tb/sv/tb_sphere_pair_overlap_resolve.sv
